// ===== hw/rtl/ftg_pkg.sv =====
// Shared types, constants and the sine table function for the foot trajectory block.
package ftg_pkg;

  localparam int DataW = 16;
  localparam int CfgAddrW = 3;

  // Register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] REG_X_OFFSET = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_Y_OFFSET = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_X_MAX    = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_X_MIN    = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_Y_MAX    = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_Y_MIN    = 3'd5;

  localparam logic signed [DataW-1:0] RST_X_OFFSET = 16'sd655;
  localparam logic signed [DataW-1:0] RST_Y_OFFSET = -16'sd7864;
  localparam logic signed [DataW-1:0] RST_X_MAX    = 16'sd5243;
  localparam logic signed [DataW-1:0] RST_X_MIN    = -16'sd5243;
  localparam logic signed [DataW-1:0] RST_Y_MAX    = -16'sd3932;
  localparam logic signed [DataW-1:0] RST_Y_MIN    = -16'sd9830;

  // One command line per datapath step, driven by the controller
  typedef struct packed {
    logic accept;
    logic prep;
    logic div_step;
    logic rom1;
    logic rom2;
    logic mul1;
    logic mul2;
    logic mul3;
    logic load_out;
  } ftg_cmd_t;

  // Quarter-wave polynomial sine, Q1.15, of a Q0.16 phase
  function automatic logic signed [DataW-1:0] sine_poly(input logic [15:0] tp);
    logic [1:0]  q;
    logic [31:0] r, z, z2, p1, p2, y;
    q  = tp[15:14];
    r  = {18'd0, tp[13:0]};
    z  = (q[0] ? (32'd16384 - r) : r) << 1;
    z2 = (z * z) >> 15;
    p1 = (32'd2611 * z2) >> 15;
    p2 = ((32'd21167 - p1) * z2) >> 15;
    y  = (z * (32'd51472 - p2)) >> 15;
    if (y > 32'd32767) y = 32'd32767;
    return q[1] ? -$signed(y[15:0]) : $signed(y[15:0]);
  endfunction

endpackage

// ===== hw/rtl/ftg_in_if.sv =====
// Input channel: one hip and one knee oscillator sample per word.
interface ftg_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hip_activity;
  logic signed [15:0] knee_activity;
  modport source (output valid, output hip_activity, output knee_activity, input ready);
  modport sink   (input valid, input hip_activity, input knee_activity, output ready);
endinterface

// ===== hw/rtl/ftg_out_if.sv =====
// Result channel: one clamped foot position per word.
interface ftg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] foot_x;
  logic signed [15:0] foot_y;
  modport source (output valid, output foot_x, output foot_y, input ready);
  modport sink   (input valid, input foot_x, input foot_y, output ready);
endinterface

// ===== hw/rtl/ftg_ctrl.sv =====
// Sequencer state machine for the foot trajectory datapath.
module ftg_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output ftg_pkg::ftg_cmd_t cmd
);
  import ftg_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_ROM1 = 9'b000001000,
    S_ROM2 = 9'b000010000,
    S_MUL1 = 9'b000100000,
    S_MUL2 = 9'b001000000,
    S_MUL3 = 9'b010000000,
    S_FIX  = 9'b100000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 4'd1;
        if (step_r == 4'hF) state_nxt = S_ROM1;
      end
      S_ROM1: begin
        cmd.rom1  = 1'b1;
        state_nxt = S_ROM2;
      end
      S_ROM2: begin
        cmd.rom2  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/ftg_dp.sv =====
// Datapath: run tracking, phase divider, sine table and cycloid arithmetic.
module ftg_dp #(
  parameter int COUNT_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ftg_pkg::ftg_cmd_t        cmd,
  input  logic signed [15:0]       hip_activity,
  input  logic signed [15:0]       knee_activity,
  input  logic                     cfg_we,
  input  logic [ftg_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [15:0]              cfg_wdata,
  output logic signed [15:0]       foot_x,
  output logic signed [15:0]       foot_y
);
  import ftg_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [CW-1:0] CMAX = {CW{1'b1}};
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_RISE = 2'd1;
  localparam logic [1:0] DIR_FALL = 2'd2;

  // configuration
  logic signed [15:0] x_off_r, y_off_r, x_max_r, x_min_r, y_max_r, y_min_r;

  // run tracking
  logic signed [15:0] prev_r [2], peak_r [2], trough_r [2];
  logic signed [15:0] prev_nxt [2], peak_nxt [2], trough_nxt [2];
  logic [1:0]         dir_r [2], dir_nxt [2];
  logic [CW-1:0]      swing_r [2], stance_r [2], swing_nxt [2], stance_nxt [2];
  logic [CW-1:0]      last_swing_r, last_stance_r, last_swing_nxt, last_stance_nxt;
  logic signed [15:0] act [2];
  logic               rise [2];

  always_comb begin
    act[0] = hip_activity;
    act[1] = knee_activity;
    for (int i = 0; i < 2; i++) begin
      rise[i]       = (act[i] >= prev_r[i]);
      swing_nxt[i]  = rise[i] ? ((swing_r[i] == CMAX) ? swing_r[i] : swing_r[i] + 1'b1) : '0;
      stance_nxt[i] = rise[i] ? '0 : ((stance_r[i] == CMAX) ? stance_r[i] : stance_r[i] + 1'b1);
      peak_nxt[i]   = (dir_r[i] == DIR_RISE && !rise[i]) ? prev_r[i] : peak_r[i];
      trough_nxt[i] = (dir_r[i] == DIR_FALL && rise[i]) ? prev_r[i] : trough_r[i];
      dir_nxt[i]    = rise[i] ? DIR_RISE : DIR_FALL;
      prev_nxt[i]   = act[i];
    end
    last_swing_nxt  = (dir_r[0] == DIR_RISE && !rise[0]) ? swing_r[0] : last_swing_r;
    last_stance_nxt = (dir_r[0] == DIR_FALL && rise[0]) ? stance_r[0] : last_stance_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= RST_X_OFFSET;
      y_off_r <= RST_Y_OFFSET;
      x_max_r <= RST_X_MAX;
      x_min_r <= RST_X_MIN;
      y_max_r <= RST_Y_MAX;
      y_min_r <= RST_Y_MIN;
      for (int i = 0; i < 2; i++) begin
        prev_r[i]   <= '0;
        peak_r[i]   <= '0;
        trough_r[i] <= '0;
        dir_r[i]    <= DIR_NONE;
        swing_r[i]  <= '0;
        stance_r[i] <= '0;
      end
      last_swing_r  <= '0;
      last_stance_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_X_OFFSET: x_off_r <= $signed(cfg_wdata);
          REG_Y_OFFSET: y_off_r <= $signed(cfg_wdata);
          REG_X_MAX:    x_max_r <= $signed(cfg_wdata);
          REG_X_MIN:    x_min_r <= $signed(cfg_wdata);
          REG_Y_MAX:    y_max_r <= $signed(cfg_wdata);
          REG_Y_MIN:    y_min_r <= $signed(cfg_wdata);
          default: ;
        endcase
      end
      if (cmd.accept) begin
        for (int i = 0; i < 2; i++) begin
          prev_r[i]   <= prev_nxt[i];
          peak_r[i]   <= peak_nxt[i];
          trough_r[i] <= trough_nxt[i];
          dir_r[i]    <= dir_nxt[i];
          swing_r[i]  <= swing_nxt[i];
          stance_r[i] <= stance_nxt[i];
        end
        last_swing_r  <= last_swing_nxt;
        last_stance_r <= last_stance_nxt;
      end
    end
  end

  // phase setup: numerator below divisor except in the saturate / zero cases
  logic          hip_fall, swing_br, half_br;
  logic [CW-1:0] num, dvs;

  always_comb begin
    hip_fall = (dir_r[0] == DIR_FALL);
    swing_br = !hip_fall && (swing_r[0] < last_swing_r);
    half_br  = ({swing_r[0], 1'b0} < {1'b0, last_swing_r});
    num      = swing_br ? swing_r[0] :
               (hip_fall ? stance_r[0] : swing_r[0] - last_swing_r);
    dvs      = swing_br ? last_swing_r : last_stance_r;
  end

  logic [CW-1:0]      rem_r, dvs_r;
  logic [15:0]        quo_r;
  logic               swing_f_r, half_f_r, sat_r, zero_r;
  logic signed [16:0] d0_r, d1_r;
  logic [CW:0]        rem2;
  logic               ge;
  logic [16:0]        phase;

  assign rem2  = {rem_r, 1'b0};
  assign ge    = (rem2 >= {1'b0, dvs_r});
  assign phase = sat_r ? 17'h10000 : (zero_r ? 17'h0 : {1'b0, quo_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rem_r     <= num;
      dvs_r     <= dvs;
      quo_r     <= '0;
      swing_f_r <= swing_br;
      half_f_r  <= half_br;
      sat_r     <= !swing_br && (dvs != '0) && (num >= dvs);
      zero_r    <= !swing_br && (dvs == '0);
      d0_r      <= 17'(peak_r[0]) - 17'(trough_r[0]);
      d1_r      <= 17'(peak_r[1]) - 17'(trough_r[1]);
    end else if (cmd.div_step) begin
      rem_r <= ge ? CW'(rem2 - {1'b0, dvs_r}) : CW'(rem2);
      quo_r <= {quo_r[14:0], ge};
    end
  end

  // sine table, registered read
  logic signed [15:0] rom_w [SINE_TABLE_DEPTH];
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [15:0] TP = 16'((k * 65536) / SINE_TABLE_DEPTH);
    assign rom_w[k] = sine_poly(TP);
  end

  function automatic logic [IW-1:0] tab_idx(input logic [15:0] turns);
    logic [31:0] prod;
    prod = 32'(turns) * 32'(SINE_TABLE_DEPTH);
    return IW'(prod >> 16);
  endfunction

  function automatic logic signed [15:0] trunc16(input logic signed [31:0] v);
    logic [31:0] mag;
    mag = v[31] ? 32'(-v) : 32'(v);
    mag = mag >> 16;
    return v[31] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
  endfunction

  logic signed [15:0] rom_q_r, s1_r, a1_r, a2_r;

  always_ff @(posedge clk) begin
    if (cmd.rom1) begin
      rom_q_r <= rom_w[tab_idx(phase[15:0])];
    end else if (cmd.rom2) begin
      s1_r    <= rom_q_r;
      rom_q_r <= rom_w[tab_idx({phase[14:0], 1'b0})];
    end
    if (cmd.mul1) begin
      a1_r <= trunc16(32'(s1_r) * 32'sd20861);
      a2_r <= trunc16(32'(rom_q_r) * 32'sd10430);
    end
  end

  // cycloid terms: x magnitude later scaled by 2^-16, y magnitude by 2^-14, sign kept aside
  logic signed [18:0] p_s, u, ex, w;
  logic signed [35:0] prod_x, prod_y;
  logic [35:0]        abs_x, abs_y;

  always_comb begin
    p_s    = $signed({2'b00, phase});
    u      = p_s - 19'(a1_r);
    ex     = swing_f_r ? (u - 19'sd32768) : (19'sd32768 - u);
    w      = half_f_r ? (p_s - 19'(a2_r)) : (19'sd65536 - p_s + 19'(a2_r));
    prod_x = 36'(d0_r) * 36'(ex);
    prod_y = 36'(d1_r) * 36'(w);
    abs_x  = prod_x[35] ? 36'(-prod_x) : 36'(prod_x);
    abs_y  = prod_y[35] ? 36'(-prod_y) : 36'(prod_y);
  end

  logic [15:0] mx_r, qx0_r;
  logic [18:0] my_r, qy0_r;
  logic        sx_r, sy_r;
  logic [31:0] rx;
  logic [39:0] ry;

  // divide by 5 and by 15 via reciprocal, one-step correction later
  assign rx = 32'(mx_r) * 32'd52429;
  assign ry = 40'(my_r) * 40'd279621;

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      mx_r <= 16'(abs_x >> 16);
      my_r <= 19'(abs_y >> 14);
      sx_r <= prod_x[35];
      sy_r <= prod_y[35];
    end
    if (cmd.mul3) begin
      qx0_r <= 16'(rx >> 18);
      qy0_r <= 19'(ry >> 22);
    end
  end

  logic [18:0]        cx;
  logic [23:0]        cy;
  logic [15:0]        qx;
  logic [18:0]        qy;
  logic signed [17:0] px, py, qxs, qys, cpx, cpy;

  always_comb begin
    cx  = 19'(qx0_r) * 19'd5;
    cy  = 24'(qy0_r) * 24'd15;
    qx  = (cx > 19'(mx_r)) ? qx0_r - 1'b1 : qx0_r;
    qy  = (cy > 24'(my_r)) ? qy0_r - 1'b1 : qy0_r;
    qxs = sx_r ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
    qys = sy_r ? -$signed(18'(qy)) : $signed(18'(qy));
    px  = 18'(x_off_r) - qxs;
    py  = swing_f_r ? 18'(y_off_r) + qys : 18'(y_off_r);
    cpx = (px > 18'(x_max_r)) ? 18'(x_max_r) : ((px < 18'(x_min_r)) ? 18'(x_min_r) : px);
    cpy = (py > 18'(y_max_r)) ? 18'(y_max_r) : ((py < 18'(y_min_r)) ? 18'(y_min_r) : py);
  end

  logic signed [15:0] foot_x_r, foot_y_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      foot_x_r <= 16'(cpx);
      foot_y_r <= 16'(cpy);
    end
  end

  assign foot_x = foot_x_r;
  assign foot_y = foot_y_r;

endmodule

// ===== hw/rtl/cycloid_foot_trajectory_generator.sv =====
// Top level of the cycloid foot trajectory generator.
//
// Usage:
//   in_word  : one word per control tick, hip and knee oscillator samples
//              (signed Q1.15). Each channel tracks rise/fall runs, peaks and
//              troughs; the hip run lengths time the gait cycle.
//   out_word : one word per input word, foot_x / foot_y in 2^-16 m, clamped
//              to the limit registers.
//   cfg_*    : write-only register port (offsets and clamp limits), used
//              while the block is idle. Out-of-range indexes are dropped.
// Timing:
//   An accepted word passes through a setup step, a restoring divider for
//   the gait phase (one quotient bit per cycle), two sine table reads through
//   one registered port, and four multiply / reciprocal-divide / clamp
//   stages. in_word.ready returns in the same cycle as the result, so the
//   block takes no new word until the last one's result has been loaded.
// Reset (rst_n, synchronous): run state cleared, registers back to their
//   defaults, output empty.
// Stall: the result waits in the output register; the next word is still
//   accepted and computed, and only its final load holds until the output
//   register has been taken.
module cycloid_foot_trajectory_generator #(
  parameter int COUNT_WIDTH      = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ftg_in_if.sink                       in_word,
  ftg_out_if.source                    out_word,
  input  logic                         cfg_we,
  input  logic [ftg_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [15:0]                  cfg_wdata
);
  import ftg_pkg::*;

  ftg_cmd_t cmd;

  ftg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_word.valid),
    .in_ready  (in_word.ready),
    .out_valid (out_word.valid),
    .out_ready (out_word.ready),
    .cmd       (cmd)
  );

  ftg_dp #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .hip_activity  (in_word.hip_activity),
    .knee_activity (in_word.knee_activity),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .foot_x        (out_word.foot_x),
    .foot_y        (out_word.foot_y)
  );

endmodule

// ===== tb/tb_cycloid_foot_trajectory_generator.sv =====
// Self-checking testbench for the cycloid foot trajectory generator.
`timescale 1ns / 1ps

module tb_cycloid_foot_trajectory_generator;
  import ftg_pkg::*;

  // Indexes past the register file; writes there must be dropped
  localparam logic [CfgAddrW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CfgAddrW-1:0] REG_SPARE_7 = 3'd7;

  localparam longint RUN_MAX     = 65535;  // run counters saturate here
  localparam int     CYCLE_LIMIT = 1500000;
  localparam int     IDLE_WAIT   = 40;     // longer than one word's trip through the block

  typedef enum logic [1:0] {TREND_NONE, TREND_RISE, TREND_FALL} trend_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } foot_pos_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [15:0] cfg_wdata;

  ftg_in_if  in_if ();
  ftg_out_if out_if ();

  cycloid_foot_trajectory_generator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if.sink),
    .out_word (out_if.source),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Shadow of the block: registers and gait tracking state
  // ---------------------------------------------------------------------
  logic signed [15:0] x_offset, y_offset, x_max, x_min, y_max, y_min;
  logic signed [15:0] prev_act [2];
  trend_t             trend [2];
  longint             swing_run [2];
  longint             stance_run [2];
  longint             last_swing, last_stance;
  logic signed [15:0] act_peak [2];
  logic signed [15:0] act_trough [2];

  foot_pos_t expected_pos_q [$];

  int errors;
  int words_sent;
  int words_checked;
  int cfg_phases;
  int cycles;
  int burst_left;

  // Table-quantized sine of a Q0.16 phase, result in Q1.15
  function automatic longint table_sine(input longint turns);
    longint unsigned idx, tp, q, r, z, z2, p1, p2, y;
    idx = ((longint'(turns) & 64'hFFFF) * 256) >> 16;
    idx = idx % 256;
    tp  = (idx * 65536) / 256;
    q   = (tp >> 14) & 3;
    r   = tp & 16'h3FFF;
    z   = ((q & 1) ? (16384 - r) : r) * 2;
    z2  = (z * z) >> 15;
    p1  = (2611 * z2) >> 15;
    p2  = ((21167 - p1) * z2) >> 15;
    y   = (z * (51472 - p2)) >> 15;
    if (y > 32767) y = 32767;
    return (q >= 2) ? -longint'(y) : longint'(y);
  endfunction

  // max test first, so with inverted limits values above max get max, all others min
  function automatic logic signed [15:0] clamp16(input longint v,
                                                 input logic signed [15:0] hi,
                                                 input logic signed [15:0] lo);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return 16'(v);
  endfunction

  // Advances the tracking state by one sample pair, returns the foot position
  function automatic foot_pos_t foot_position_after(input logic signed [15:0] hip,
                                                    input logic signed [15:0] knee);
    logic signed [15:0] a [2];
    trend_t    nd;
    longint    old_up, old_down, ty, t, f, g, u, w, v, d0, d1, px, py;
    foot_pos_t p;
    a[0] = hip;
    a[1] = knee;
    for (int i = 0; i < 2; i++) begin
      nd       = (a[i] >= prev_act[i]) ? TREND_RISE : TREND_FALL;
      old_up   = swing_run[i];
      old_down = stance_run[i];
      if (nd == TREND_RISE) begin
        if (swing_run[i] < RUN_MAX) swing_run[i]++;
        stance_run[i] = 0;
      end else begin
        if (stance_run[i] < RUN_MAX) stance_run[i]++;
        swing_run[i] = 0;
      end
      if (trend[i] == TREND_RISE && nd == TREND_FALL) begin
        if (i == 0) last_swing = old_up;
        act_peak[i] = prev_act[i];
      end
      if (trend[i] == TREND_FALL && nd == TREND_RISE) begin
        if (i == 0) last_stance = old_down;
        act_trough[i] = prev_act[i];
      end
      trend[i]    = nd;
      prev_act[i] = a[i];
    end

    ty = last_swing;
    t  = (trend[0] == TREND_FALL) ? ty + stance_run[0] : swing_run[0];
    d0 = longint'(act_peak[0]) - longint'(act_trough[0]);
    d1 = longint'(act_peak[1]) - longint'(act_trough[1]);

    if (t < ty) begin
      // swing arc
      f  = (t * 65536) / ty;
      u  = f - (table_sine(f) * 20861) / 65536;
      px = longint'(x_offset) - (d0 * (u - 32768)) / 327680;
      if (2 * t < ty) w = f - (table_sine(2 * f) * 10430) / 65536;
      else            w = 65536 - f + (table_sine(2 * f) * 10430) / 65536;
      py = longint'(y_offset) + (4 * d1 * w) / 983040;
    end else begin
      // stance return; no stance seen yet gives phase 0
      g = 0;
      if (last_stance != 0) begin
        g = ((t - ty) * 65536) / last_stance;
        if (g > 65536) g = 65536;
      end
      v  = g - (table_sine(g) * 20861) / 65536;
      px = longint'(x_offset) - (d0 * (32768 - v)) / 327680;
      py = longint'(y_offset);
    end
    p.x = clamp16(px, x_max, x_min);
    p.y = clamp16(py, y_max, y_min);
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles,
               expected_pos_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------
  int stall_left;
  int stall_mode;

  // Modes: always ready, coin flip, mostly stalled, periodic short stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_if.ready <= 1'b1;
      end
      1: begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_if.ready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        out_if.ready <= (stall_left[3:0] != 4'd0);
      end
    endcase
  end

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin : check_words
    foot_pos_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_pos_q.size() == 0) begin
        report($sformatf("result word with nothing expected x=%0d y=%0d",
                         out_if.foot_x, out_if.foot_y));
      end else begin
        e = expected_pos_q.pop_front();
        if (out_if.foot_x !== e.x)
          report($sformatf("foot_x got %0d want %0d", out_if.foot_x, e.x));
        if (out_if.foot_y !== e.y)
          report($sformatf("foot_y got %0d want %0d", out_if.foot_y, e.y));
        words_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // One sample word; the sender works in bursts separated by random gaps
  task automatic send_word(input logic signed [15:0] hip,
                           input logic signed [15:0] knee);
    int gap;
    in_if.valid         <= 1'b1;
    in_if.hip_activity  <= hip;
    in_if.knee_activity <= knee;
    do @(posedge clk); while (!in_if.ready);
    expected_pos_q.push_back(foot_position_after(hip, knee));
    words_sent++;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 30);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Block must be idle before a register write
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_pos_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_X_OFFSET: x_offset = val;
      REG_Y_OFFSET: y_offset = val;
      REG_X_MAX:    x_max    = val;
      REG_X_MIN:    x_min    = val;
      REG_Y_MAX:    y_max    = val;
      REG_Y_MIN:    y_min    = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] sat16(input int v);
    if (v > 32767)  return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Register value: extremes, anything, or near the default scale
  function automatic logic [15:0] pick_reg_value(input logic signed [15:0] dflt);
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom());
      default: return 16'(int'(dflt) + $urandom_range(0, 8000) - 4000);
    endcase
  endfunction

  // Oscillator-like samples: each channel ramps up, then down, with random
  // run lengths and slopes. Rising steps may be zero (still a rise).
  task automatic send_gait(input int n);
    int  lvl [2];
    bit  up [2];
    int  left [2];
    int  slope [2];
    for (int c = 0; c < 2; c++) begin
      lvl[c]  = $urandom_range(0, 40000) - 20000;
      up[c]   = $urandom_range(0, 1);
      left[c] = 0;
    end
    repeat (n) begin
      for (int c = 0; c < 2; c++) begin
        if (left[c] == 0) begin
          up[c]    = !up[c];
          left[c]  = $urandom_range(1, 40);
          slope[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30000)
                                                 : $urandom_range(0, 2000);
        end
        if (up[c]) lvl[c] = int'(sat16(lvl[c] + $urandom_range(0, slope[c])));
        else       lvl[c] = int'(sat16(lvl[c] - 1 - $urandom_range(0, slope[c])));
        left[c]--;
      end
      send_word(16'(lvl[0]), 16'(lvl[1]));
    end
  endtask

  task automatic send_noise(input int n);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       send_word(16'sh7FFF, 16'sh8000);
        1:       send_word(16'sh8000, 16'sh7FFF);
        default: send_word(16'($urandom()), 16'($urandom()));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // First samples come from no trend; a fall before any trough leaves a
  // zero stance divisor; a swing of zero length takes the stance branch.
  task automatic test_first_samples();
    send_word(16'sh0000, 16'sh0000);
    send_word(16'sh7FFF, 16'sh8000);
    send_word(16'sh7FFF, 16'sh8000);
    send_word(16'sh8000, 16'sh7FFF);
    send_word(-16'sd30000, 16'sh7FFF);
    send_word(-16'sd31000, 16'sh0100);
  endtask

  // Swing then a stance longer than the last one: phase saturates at 1
  task automatic test_stance_overrun();
    send_word(-16'sd20000, -16'sd20000);
    send_word(16'sd0, 16'sd0);
    send_word(16'sd20000, 16'sd25000);
    send_word(16'sd30000, 16'sd32767);
    send_word(16'sd10000, 16'sd1000);
    send_word(16'sd0, -16'sd9000);
    send_word(-16'sd10000, -16'sd15000);
    send_word(-16'sd20000, -16'sd32768);
    send_word(-16'sd30000, -16'sd32768);
  endtask

  // Dropped indexes, inverted limits and extreme registers
  task automatic test_register_corners();
    wait_idle();
    write_reg(REG_SPARE_6, 16'hFFFF);
    write_reg(REG_SPARE_7, 16'h8000);
    write_reg(REG_X_MAX, 16'h8000);
    write_reg(REG_X_MIN, 16'h7FFF);
    write_reg(REG_Y_MAX, -16'sd9000);
    write_reg(REG_Y_MIN, -16'sd4000);
    send_gait(5);
    wait_idle();
    write_reg(REG_X_OFFSET, 16'h7FFF);
    write_reg(REG_Y_OFFSET, 16'h8000);
    write_reg(REG_X_MAX, 16'h7FFF);
    write_reg(REG_X_MIN, 16'h8000);
    write_reg(REG_Y_MAX, 16'h7FFF);
    write_reg(REG_Y_MIN, 16'h8000);
    send_gait(5);
    cfg_phases += 2;
  endtask

  // Phases of random registers with mostly gait-shaped traffic
  task automatic test_random_gaits(input int total);
    int n;
    while (total > 0) begin
      wait_idle();
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_X_OFFSET, RST_X_OFFSET);
        write_reg(REG_Y_OFFSET, RST_Y_OFFSET);
        write_reg(REG_X_MAX, RST_X_MAX);
        write_reg(REG_X_MIN, RST_X_MIN);
        write_reg(REG_Y_MAX, RST_Y_MAX);
        write_reg(REG_Y_MIN, RST_Y_MIN);
      end else begin
        write_reg(REG_X_OFFSET, pick_reg_value(RST_X_OFFSET));
        write_reg(REG_Y_OFFSET, pick_reg_value(RST_Y_OFFSET));
        write_reg(REG_X_MAX, pick_reg_value(RST_X_MAX));
        write_reg(REG_X_MIN, pick_reg_value(RST_X_MIN));
        write_reg(REG_Y_MAX, pick_reg_value(RST_Y_MAX));
        write_reg(REG_Y_MIN, pick_reg_value(RST_Y_MIN));
      end
      cfg_phases++;
      n = $urandom_range(100, 250);
      if ($urandom_range(0, 4) == 0) send_noise(n);
      else                           send_gait(n);
      total -= n;
    end
  endtask

  initial begin
    errors        = 0;
    words_sent    = 0;
    words_checked = 0;
    cfg_phases    = 0;
    cycles        = 0;
    burst_left    = 0;
    stall_left    = 0;
    stall_mode    = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    in_if.valid         = 1'b0;
    in_if.hip_activity  = '0;
    in_if.knee_activity = '0;
    out_if.ready        = 1'b0;

    x_offset = RST_X_OFFSET;
    y_offset = RST_Y_OFFSET;
    x_max    = RST_X_MAX;
    x_min    = RST_X_MIN;
    y_max    = RST_Y_MAX;
    y_min    = RST_Y_MIN;
    for (int i = 0; i < 2; i++) begin
      prev_act[i]   = '0;
      trend[i]      = TREND_NONE;
      swing_run[i]  = 0;
      stance_run[i] = 0;
      act_peak[i]   = '0;
      act_trough[i] = '0;
    end
    last_swing  = 0;
    last_stance = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_samples();
    test_stance_overrun();
    test_register_corners();
    test_random_gaits(1750);

    wait_idle();

    $display("Sent %0d sample words over %0d register settings; %0d results checked.",
             words_sent, cfg_phases + 1, words_checked);
    $display("Mismatches: %0d", errors);
    if (errors == 0 && expected_pos_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
